// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

   // Configuration port.
   localparam int CFG_DATA_W = 64;
   localparam int CFG_IDX_W  = 3;
   localparam int LEN_W      = 5;
   localparam int STR_BITS   = 2 * CFG_DATA_W;

   localparam logic [CFG_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_PATTERN_LOW    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_PATTERN_HIGH   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_REPLACE_LENGTH = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CSR_REPLACE_LOW    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CSR_REPLACE_HIGH   = 3'd5;

   // Command queue between the front and the back.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_REPL = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_front.sv =====
// Front end: keeps the pending window, matches it against the pattern and issues commands.
`default_nettype none

module sfr_front
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = 16,
   localparam int CW = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_push,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_last,
   input  wire logic                clear,
   input  wire logic [CW-1:0]       plen,
   input  wire logic [STR_BITS-1:0] pattern,
   input  wire logic                repl_nz,
   input  wire logic                q_full,
   output logic                     busy,
   output logic                     cmd_push,
   output cmd_type                  cmd
);

   logic [7:0]    win_ff [MAX_PATTERN];
   logic [7:0]    win_in [MAX_PATTERN];
   logic [7:0]    cand   [MAX_PATTERN];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          flush_ff, flush_in;
   logic          all_eq, win_full, hit, miss;
   logic [CW-1:0] step_cnt;

   // The window with the new item written in at the fill position.
   always_comb begin
      all_eq = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         cand[i] = (cnt_ff == CW'(i)) ? in_byte : win_ff[i];
         if (CW'(i) < plen && cand[i] != 8'(pattern >> (8 * i))) begin
            all_eq = 1'b0;
         end
      end
      win_full = (cnt_ff + CW'(1)) == plen;
      hit      = win_full && all_eq;
      miss     = win_full && !all_eq;
      if (hit) begin
         step_cnt = '0;
      end else if (miss) begin
         step_cnt = cnt_ff;
      end else begin
         step_cnt = cnt_ff + CW'(1);
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      win_in   = win_ff;
      cmd_push = 1'b0;
      cmd      = '{kind: CMD_BYTE, data: cand[0], last: 1'b0};
      priority if (clear) begin
         cnt_in = '0;
      end else if (flush_ff) begin
         // Drain the window one item per cycle while the queue is not full, after the last input item.
         if (!q_full) begin
            cmd_push = 1'b1;
            cmd      = '{kind: CMD_BYTE, data: win_ff[0], last: cnt_ff == CW'(1)};
            for (int j = 0; j < MAX_PATTERN - 1; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            cnt_in   = cnt_ff - CW'(1);
            flush_in = cnt_ff != CW'(1);
         end
      end else if (in_push) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            win_in[j] = cand[j];
         end
         if (miss) begin
            for (int j = 0; j < MAX_PATTERN - 1; j++) begin
               win_in[j] = cand[j + 1];
            end
         end
         cnt_in = step_cnt;
         if (miss) begin
            cmd_push = 1'b1;
            cmd      = '{kind: CMD_BYTE, data: cand[0], last: 1'b0};
         end else if (hit && repl_nz) begin
            cmd_push = 1'b1;
            cmd      = '{kind: CMD_REPL, data: 8'd0, last: 1'b0};
         end
         if (in_last) begin
            flush_in = step_cnt != '0;
            if (step_cnt == '0) begin
               // Nothing left to flush, so this command closes the stream.
               cmd_push = 1'b1;
               cmd.last = 1'b1;
               if (!miss && !(hit && repl_nz)) begin
                  cmd = '{kind: CMD_END, data: 8'd0, last: 1'b1};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign busy = flush_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_queue.sv =====
// Short command queue that decouples the front end from the back end.
`default_nettype none

module sfr_queue
   import sfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type din,
   input  wire logic    pop,
   output cmd_type      dout,
   output logic         full,
   output logic         empty
);

   cmd_type           mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign full    = count_ff == Q_CW'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + Q_CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - Q_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_back.sv =====
// Back end: expands commands into result items and holds the output register.
`default_nettype none

module sfr_back
   import sfr_pkg::*;
#(
   parameter int MAX_REPLACE = 16,
   localparam int RW = $clog2(MAX_REPLACE + 2)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire cmd_type             head,
   output logic                     q_pop,
   input  wire logic [RW-1:0]       rlen,
   input  wire logic [STR_BITS-1:0] replace,
   input  wire logic                rsp_pop,
   output logic                     rsp_empty,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_no_data,
   output logic                     rsp_out_last
);

   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          no_data_ff, no_data_in;
   logic          last_ff, last_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic          out_ready, step, rep_done;

   // The output register takes a new item when it is empty or being drained.
   assign out_ready = !valid_ff || rsp_pop;
   assign step      = !q_empty && out_ready;
   assign rep_done  = (idx_ff + RW'(1)) == rlen;

   always_comb begin
      valid_in   = valid_ff && !rsp_pop;
      byte_in    = byte_ff;
      no_data_in = no_data_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      if (step) begin
         valid_in = 1'b1;
         unique case (head.kind)
            CMD_BYTE: begin
               byte_in    = head.data;
               no_data_in = 1'b0;
               last_in    = head.last;
               q_pop      = 1'b1;
            end
            CMD_REPL: begin
               byte_in    = 8'(replace >> {idx_ff, 3'b000});
               no_data_in = 1'b0;
               last_in    = head.last && rep_done;
               q_pop      = rep_done;
               idx_in     = rep_done ? '0 : idx_ff + RW'(1);
            end
            default: begin
               byte_in    = 8'd0;
               no_data_in = 1'b1;
               last_in    = 1'b1;
               q_pop      = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      no_data_ff <= no_data_in;
      last_ff    <= last_in;
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_no_data  = no_data_ff;
   assign rsp_out_last = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/stream_find_replace.sv =====
// Streaming find-and-replace over a byte stream.
//
// Input items are bytes pushed on req_push while req_full is low; req_in_last
// marks the final byte of a stream. Result items appear on the rsp_ ports
// while rsp_empty is low and leave on rsp_pop. Each left-to-right,
// non-overlapping occurrence of the pattern is replaced by the replacement
// string; at the end of a stream the pending window is flushed and the last
// result carries rsp_out_last. A stream that ends with nothing to emit gives
// one item with rsp_no_data set.
// A byte can follow each cycle while req_full is low. A replacement keeps one
// queue entry while its bytes leave in order; the four-entry command queue
// absorbs short bursts and req_full rises once it fills. After a final byte
// the pending window is flushed one item per cycle while the queue has room,
// and req_full stays high. Configuration is written on csr_we; the user must
// write it only while the block is idle, which the block does not enforce.
// Writing the pattern length discards the pending window. Reset restores
// pattern length one, replacement length zero, clears all strings and empties
// the queue. A stalled receiver holds the output item, fills the queue and
// then raises req_full; nothing is dropped.
`default_nettype none

module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_REPLACE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_in_last,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_no_data,
   output logic                       rsp_out_last,
   input  wire logic                  csr_we,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata
);

   localparam int PCW = $clog2(MAX_PATTERN + 1);
   localparam int RCW = $clog2(MAX_REPLACE + 2);

   logic [LEN_W-1:0]      pattern_length_ff;
   logic [CFG_DATA_W-1:0] pattern_low_ff, pattern_high_ff;
   logic [LEN_W-1:0]      replace_length_ff;
   logic [CFG_DATA_W-1:0] replace_low_ff, replace_high_ff;

   logic [LEN_W-1:0] plen_raw;
   logic [PCW-1:0]   plen;
   logic [RCW-1:0]   rlen;
   logic             in_push, front_busy, clear_window;
   logic             q_push, q_pop, q_full, q_empty;
   cmd_type          q_din, q_dout;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_W'(1);
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         replace_length_ff <= '0;
         replace_low_ff    <= '0;
         replace_high_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_REPLACE_LENGTH: replace_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_REPLACE_LOW:    replace_low_ff    <= csr_wdata;
            CSR_REPLACE_HIGH:   replace_high_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A zero pattern length acts as one; both lengths saturate at the maximum.
   assign plen_raw = (pattern_length_ff == '0) ? LEN_W'(1) : pattern_length_ff;
   assign plen     = (int'(plen_raw) > MAX_PATTERN) ? PCW'(MAX_PATTERN) : PCW'(plen_raw);
   assign rlen     = (int'(replace_length_ff) > MAX_REPLACE) ? RCW'(MAX_REPLACE)
                                                             : RCW'(replace_length_ff);

   assign clear_window = csr_we && csr_index == CSR_PATTERN_LENGTH;
   assign req_full     = front_busy || q_full;
   assign in_push      = req_push && !req_full;

   sfr_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (in_push),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .clear    (clear_window),
      .plen     (plen),
      .pattern  ({pattern_high_ff, pattern_low_ff}),
      .repl_nz  (rlen != '0),
      .q_full   (q_full),
      .busy     (front_busy),
      .cmd_push (q_push),
      .cmd      (q_din)
   );

   sfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   sfr_back #(
      .MAX_REPLACE (MAX_REPLACE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head         (q_dout),
      .q_pop        (q_pop),
      .rlen         (rlen),
      .replace      ({replace_high_ff, replace_low_ff}),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_no_data  (rsp_no_data),
      .rsp_out_last (rsp_out_last)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_no_data) |-> (rsp_out_last && rsp_out_byte == 8'd0))
      else $error("end marker item without last flag or with data");

   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      front_busy |-> !in_push)
      else $error("item accepted while the window is being flushed");
`endif

endmodule

`default_nettype wire

// ===== tb/stream_find_replace_tb.sv =====
// Self-checking testbench for the stream find-and-replace block.
`timescale 1ns / 100ps

module stream_find_replace_tb
   import sfr_pkg::*;
();

   localparam int MAX_PAT   = 16;
   localparam int MAX_REP   = 16;
   localparam int DRAIN     = 24;
   localparam int IDLE_PCT  = 7;
   localparam int PHASES    = 12;
   localparam int PHASE_LEN = 34;

   // Indexes past the last register; writes there must change nothing.
   localparam logic [CFG_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } in_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       no_data;
      logic       last;
   } out_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [7:0]            req_in_byte = 8'd0;
   logic                  req_in_last = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_no_data;
   logic                  rsp_out_last;
   logic                  csr_we = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   stream_find_replace u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_no_data  (rsp_no_data),
      .rsp_out_last (rsp_out_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Register copies and the pending match window.
   logic [LEN_W-1:0] cfg_pat_len = 5'd1;
   logic [63:0]      cfg_pat_lo  = '0;
   logic [63:0]      cfg_pat_hi  = '0;
   logic [LEN_W-1:0] cfg_rep_len = 5'd0;
   logic [63:0]      cfg_rep_lo  = '0;
   logic [63:0]      cfg_rep_hi  = '0;
   logic [7:0]       win_bytes [MAX_PAT];
   int               win_count = 0;

   in_item_type  byte_feed_q [$];
   out_item_type rewritten_q [$];
   int           bytes_fed = 0;
   int           bytes_taken = 0;
   int           mismatches = 0;
   bit           steady = 1'b0;

   function automatic int eff_pat_len();
      if (cfg_pat_len == 0) return 1;
      if (cfg_pat_len > MAX_PAT) return MAX_PAT;
      return int'(cfg_pat_len);
   endfunction

   function automatic int eff_rep_len();
      if (cfg_rep_len > MAX_REP) return MAX_REP;
      return int'(cfg_rep_len);
   endfunction

   function automatic logic [7:0] pat_byte(input int i);
      logic [127:0] s;
      s = {cfg_pat_hi, cfg_pat_lo};
      return s[8*i +: 8];
   endfunction

   function automatic logic [7:0] rep_byte(input int i);
      logic [127:0] s;
      s = {cfg_rep_hi, cfg_rep_lo};
      return s[8*i +: 8];
   endfunction

   // Rewrites one accepted byte and queues the bytes it releases.
   task automatic rewrite_byte(input logic [7:0] b, input logic last);
      out_item_type outs [$];
      out_item_type o;
      int           plen;
      int           i;
      logic         hit;
      plen = eff_pat_len();
      win_bytes[win_count] = b;
      win_count++;
      if (win_count >= plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++) begin
            if (win_bytes[i] != pat_byte(i)) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < eff_rep_len(); i++) begin
               o = '{data: rep_byte(i), no_data: 1'b0, last: 1'b0};
               outs.insert(outs.size(), o);
            end
            win_count = 0;
         end else begin
            o = '{data: win_bytes[0], no_data: 1'b0, last: 1'b0};
            outs.insert(outs.size(), o);
            for (i = 0; i < MAX_PAT - 1; i++) win_bytes[i] = win_bytes[i+1];
            win_count--;
         end
      end
      if (last) begin
         for (i = 0; i < win_count; i++) begin
            o = '{data: win_bytes[i], no_data: 1'b0, last: 1'b0};
            outs.insert(outs.size(), o);
         end
         win_count = 0;
         if (outs.size() == 0) begin
            o = '{data: 8'd0, no_data: 1'b1, last: 1'b1};
            outs.insert(outs.size(), o);
         end else begin
            outs[outs.size()-1].last = 1'b1;
         end
      end
      foreach (outs[k]) rewritten_q.insert(rewritten_q.size(), outs[k]);
   endtask

   // Input side: one item per accepted push, fed from the pending queue.
   always @(posedge clock) begin
      in_item_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            rewrite_byte(req_in_byte, req_in_last);
            bytes_taken++;
         end
         if (!req_push || !req_full) begin
            if (byte_feed_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = byte_feed_q.pop_front();
               req_push    <= 1'b1;
               req_in_byte <= nxt.data;
               req_in_last <= nxt.last;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Output side: checks each popped item against the oldest prediction.
   always @(posedge clock) begin
      out_item_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (rewritten_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual byte %h no_data %b last %b",
                        $realtime, rsp_out_byte, rsp_no_data, rsp_out_last);
               mismatches++;
            end else begin
               want = rewritten_q.pop_front();
               // The byte carries nothing on an end-only item.
               if (!want.no_data && rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $realtime, want.data, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_no_data !== want.no_data) begin
                  $display("%0t: no_data mismatch: expected %b, actual %b",
                           $realtime, want.no_data, rsp_no_data);
                  mismatches++;
               end
               if (rsp_out_last !== want.last) begin
                  $display("%0t: out_last mismatch: expected %b, actual %b",
                           $realtime, want.last, rsp_out_last);
                  mismatches++;
               end
            end
         end
         rsp_pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic feed(input logic [7:0] b, input logic last);
      in_item_type it;
      it = '{data: b, last: last};
      byte_feed_q.insert(byte_feed_q.size(), it);
      bytes_fed++;
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         CSR_PATTERN_LENGTH: begin
            cfg_pat_len = val[LEN_W-1:0];
            win_count   = 0;
         end
         CSR_PATTERN_LOW:    cfg_pat_lo  = val;
         CSR_PATTERN_HIGH:   cfg_pat_hi  = val;
         CSR_REPLACE_LENGTH: cfg_rep_len = val[LEN_W-1:0];
         CSR_REPLACE_LOW:    cfg_rep_lo  = val;
         CSR_REPLACE_HIGH:   cfg_rep_hi  = val;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every item is taken and every predicted byte has left.
   task automatic settle();
      while (bytes_taken != bytes_fed || rewritten_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Random stream built mostly from whole or partial copies of the pattern.
   task automatic feed_stream(input int count);
      int made;
      int kind;
      int frag;
      int bad;
      int plen;
      int j;
      logic [7:0] b;
      made = 0;
      plen = eff_pat_len();
      while (made < count) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4 || kind == 7) frag = plen;
         else if (kind <= 6) frag = $urandom_range(1, plen);
         else frag = 1;
         bad = $urandom_range(0, frag - 1);
         for (j = 0; j < frag; j++) begin
            if (kind >= 8 || (kind == 7 && j == bad)) b = 8'($urandom_range(0, 255));
            else b = pat_byte(j);
            feed(b, $urandom_range(0, 29) == 0);
         end
         made += frag;
      end
      if ($urandom_range(0, 1) == 1) feed(8'($urandom_range(0, 255)), 1'b1);
   endtask

   int plen_pick [PHASES] = '{1, 2, 16, 3, 31, 0, 4, 8, 17, 5, -1, -1};
   int rlen_pick [PHASES] = '{0, 16, 31, 1, 3, 0, 2, 20, 16, 4, -1, -1};

   initial begin
      int p;
      int v;
      logic [7:0] fill;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a one-byte pattern of zero that is deleted.
      feed(8'h00, 1'b1);
      feed(8'hFF, 1'b0);
      feed(8'h00, 1'b0);
      feed(8'h80, 1'b1);
      settle();

      write_reg(CSR_PATTERN_LENGTH, 64'd3);
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0043_4241);
      write_reg(CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_REPLACE_LENGTH, 64'd16);
      write_reg(CSR_REPLACE_LOW, 64'hFFEE_DDCC_BBAA_9988);
      write_reg(CSR_REPLACE_HIGH, 64'h0123_4567_89AB_CDEF);
      write_reg(CSR_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_SPARE_B, 64'h5A5A_5A5A_5A5A_5A5A);
      end_writes();
      feed(8'h41, 1'b0);
      feed(8'h42, 1'b0);
      feed(8'h43, 1'b0);
      feed(8'h41, 1'b0);
      feed(8'h42, 1'b0);
      feed(8'h41, 1'b0);
      feed(8'h42, 1'b0);
      feed(8'h43, 1'b0);
      // A match that ends on the final byte is still replaced.
      feed(8'h41, 1'b0);
      feed(8'h42, 1'b0);
      feed(8'h43, 1'b1);
      settle();

      // Length zero acts as one; a replacement length above the maximum saturates.
      write_reg(CSR_PATTERN_LENGTH, 64'd0);
      write_reg(CSR_PATTERN_LOW, 64'h55);
      write_reg(CSR_REPLACE_LENGTH, 64'd31);
      end_writes();
      feed(8'h55, 1'b1);
      feed(8'h41, 1'b1);
      settle();

      // A pattern length above the maximum saturates; a short stream is flushed.
      write_reg(CSR_PATTERN_LENGTH, 64'd17);
      write_reg(CSR_PATTERN_LOW, 64'd0);
      end_writes();
      repeat (4) feed(8'h00, 1'b0);
      feed(8'h00, 1'b1);
      settle();

      for (p = 0; p < PHASES; p++) begin
         steady = (p == 3 || p == 4);
         if (p < 2 || $urandom_range(0, 3) != 0) begin
            v = (plen_pick[p] < 0) ? $urandom_range(0, 31) : plen_pick[p];
            write_reg(CSR_PATTERN_LENGTH, 64'(v));
         end
         if ($urandom_range(0, 3) == 0) begin
            // Repeated bytes exercise overlapping candidates.
            fill = 8'($urandom_range(0, 255));
            write_reg(CSR_PATTERN_LOW, {8{fill}});
            write_reg(CSR_PATTERN_HIGH, {8{fill}});
         end else begin
            write_reg(CSR_PATTERN_LOW, {$urandom, $urandom});
            write_reg(CSR_PATTERN_HIGH, {$urandom, $urandom});
         end
         v = (rlen_pick[p] < 0) ? $urandom_range(0, 31) : rlen_pick[p];
         write_reg(CSR_REPLACE_LENGTH, 64'(v));
         write_reg(CSR_REPLACE_LOW, {$urandom, $urandom});
         write_reg(CSR_REPLACE_HIGH, {$urandom, $urandom});
         end_writes();
         feed_stream(PHASE_LEN);
         settle();
      end
      steady = 1'b0;

      if (mismatches == 0 && rewritten_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace.sv
tb/stream_find_replace_tb.sv
